// ===== rtl/tslru_pkg.sv =====
// ----------------------------------------------------------------------------
// tslru_pkg : shared definitions for the LRU/FIFO tag store
// Field widths, stream packing offsets, request codes and register indexes.
// ----------------------------------------------------------------------------
package tslru_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int ACTION_W   = 2;
    localparam int TAG_W      = 64;
    localparam int CNT_W      = 5;
    localparam int CAP_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Slave stream packing: action, tag.
    localparam int S_DATA_W     = 72;
    localparam int S_ACTION_LSB = 0;
    localparam int S_TAG_LSB    = S_ACTION_LSB + ACTION_W;

    // Master stream packing: hit, evicted_valid, evicted_tag, occupancy.
    localparam int M_DATA_W      = 72;
    localparam int M_HIT_BIT     = 0;
    localparam int M_EVV_BIT     = 1;
    localparam int M_EVTAG_LSB   = 2;
    localparam int M_OCC_LSB     = M_EVTAG_LSB + TAG_W;
    localparam int M_USED_W      = M_OCC_LSB + CNT_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACCESS   = 2'd0,
        ACT_INSERT   = 2'd1,
        ACT_REMOVE   = 2'd2,
        ACT_CONTAINS = 2'd3
    } action_t;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 1'b1;

    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

// ===== rtl/tag_store_lru_fifo_replacement_core.sv =====
// ----------------------------------------------------------------------------
// tag_store_lru_fifo_replacement_core : fully associative tag store
// Parallel tag compare with LRU or FIFO victim selection and one result per
// request.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the s_ stream: tdata carries a 2-bit action (access,
//   insert, remove, contains query) and a 64-bit tag. Each accepted
//   transaction produces exactly one result transaction on the m_ stream,
//   reporting the hit, any evicted victim and the occupancy after the request.
//   Every tag held in the store is compared in parallel and all age ranks are
//   updated in the same cycle, so one request is taken per clock cycle while
//   results are being taken, and its result appears in the output register in
//   the cycle after acceptance. The loop through the entry flops (compare,
//   rank update, write back) is what allows this rate.
//   When the receiver stalls, the result waits in the output register and
//   s_tready falls; it rises again in the cycle the result is taken, so a
//   request may be accepted in the same cycle as the previous result leaves.
//   Reset (aresetn low, synchronous) empties the store, drops any pending
//   result, and restores capacity 16 and the LRU policy.
//   Configuration writes on the cfg_ port take effect at once and are only
//   honoured while the store is empty.
// ----------------------------------------------------------------------------
module tag_store_lru_fifo_replacement_core #(
    parameter int MAX_ENTRIES = tslru_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: action[1:0], tag[65:2], zero pad[71:66]
    input  logic [tslru_pkg::S_DATA_W-1:0]    s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: hit[0], evicted_valid[1], evicted_tag[65:2],
    // occupancy[70:66], zero pad[71]
    output logic [tslru_pkg::M_DATA_W-1:0]    m_tdata,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [tslru_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tslru_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int RankW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IdxW  = RankW;
    // The internal count holds 0..MAX_ENTRIES; the reported occupancy keeps
    // only its low bits.
    localparam int CntW  = $clog2(MAX_ENTRIES + 1);
    localparam int WideW = (RankW > CntW) ? RankW : CntW;
    localparam int CmpW  = ((WideW > tslru_pkg::CAP_W) ? WideW : tslru_pkg::CAP_W) + 1;

    // Entry storage. Tags have no reset; an invalid entry is never compared.
    logic [tslru_pkg::TAG_W-1:0] tag_reg   [MAX_ENTRIES];
    logic [RankW-1:0]            rank_reg  [MAX_ENTRIES];
    logic [RankW-1:0]            rank_next [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]      valid_reg;
    logic [MAX_ENTRIES-1:0]      valid_next;
    logic [CntW-1:0]             count_reg;
    logic [CntW-1:0]             count_next;

    logic [tslru_pkg::CAP_W-1:0] cap_reg;
    logic                        policy_reg;

    logic                          m_valid_reg;
    logic [tslru_pkg::M_DATA_W-1:0] m_data_reg;
    logic [tslru_pkg::M_DATA_W-1:0] m_data_next;

    logic                          accept;
    tslru_pkg::action_t            req_action;
    logic [tslru_pkg::TAG_W-1:0]   req_tag;

    logic [MAX_ENTRIES-1:0]        match;
    logic [MAX_ENTRIES-1:0]        victim;
    logic [MAX_ENTRIES-1:0]        free_slots;
    logic                          hit;
    logic [RankW-1:0]              hit_rank;
    logic [tslru_pkg::TAG_W-1:0]   victim_tag;
    logic                          full;
    logic                          evict;
    logic                          tag_write;
    logic [IdxW-1:0]               slot_idx;

    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign req_action = tslru_pkg::action_t'(
        s_tdata[tslru_pkg::S_ACTION_LSB +: tslru_pkg::ACTION_W]);
    assign req_tag    = s_tdata[tslru_pkg::S_TAG_LSB +: tslru_pkg::TAG_W];

    // Parallel compare against every entry. Valid tags are unique, so at most
    // one match; the victim is the valid entry whose rank is count - 1.
    always_comb begin
        hit        = 1'b0;
        hit_rank   = '0;
        victim_tag = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i]  = valid_reg[i] && (tag_reg[i] == req_tag);
            victim[i] = valid_reg[i] &&
                        ((CmpW'(rank_reg[i]) + CmpW'(1)) == CmpW'(count_reg));
            hit       = hit | match[i];
            hit_rank  = hit_rank | (match[i] ? rank_reg[i] : '0);
            victim_tag = victim_tag | (victim[i] ? tag_reg[i] : '0);
        end
    end

    // The effective capacity is the register clamped into 1..MAX_ENTRIES.
    always_comb begin
        if (cap_reg == '0) begin
            full = (count_reg != '0);
        end else begin
            full = (CmpW'(count_reg) >= CmpW'(cap_reg));
        end
        if (CmpW'(count_reg) >= CmpW'(MAX_ENTRIES)) begin
            full = 1'b1;
        end
    end

    // First free entry, counting the victim as free when one is evicted.
    always_comb begin
        free_slots = ~valid_reg | (full ? victim : '0);
        slot_idx   = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (free_slots[i]) begin
                slot_idx = IdxW'(i);
            end
        end
    end

    // Next state of the ranks, valid bits and count for the current request.
    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        evict      = 1'b0;
        tag_write  = 1'b0;
        case (req_action)
            tslru_pkg::ACT_ACCESS, tslru_pkg::ACT_INSERT: begin
                if (hit) begin
                    if (policy_reg == tslru_pkg::POLICY_LRU) begin
                        for (int i = 0; i < MAX_ENTRIES; i++) begin
                            if (match[i]) begin
                                rank_next[i] = '0;
                            end else if (valid_reg[i] && rank_reg[i] < hit_rank) begin
                                rank_next[i] = rank_reg[i] + RankW'(1);
                            end
                        end
                    end
                end else if (req_action == tslru_pkg::ACT_INSERT) begin
                    evict     = full;
                    tag_write = 1'b1;
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (valid_reg[i] && !(full && victim[i])) begin
                            rank_next[i] = rank_reg[i] + RankW'(1);
                        end
                    end
                    valid_next = valid_reg & ~(full ? victim : '0);
                    valid_next[slot_idx] = 1'b1;
                    rank_next[slot_idx]  = '0;
                    if (!full) begin
                        count_next = count_reg + CntW'(1);
                    end
                end
            end
            tslru_pkg::ACT_REMOVE: begin
                if (hit) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (valid_reg[i] && rank_reg[i] > hit_rank) begin
                            rank_next[i] = rank_reg[i] - RankW'(1);
                        end
                    end
                    valid_next = valid_reg & ~match;
                    count_next = count_reg - CntW'(1);
                end
            end
            default: begin
                // A contains query only reports the hit.
            end
        endcase
    end

    always_comb begin
        m_data_next = '0;
        m_data_next[tslru_pkg::M_HIT_BIT] = hit;
        m_data_next[tslru_pkg::M_EVV_BIT] = evict;
        m_data_next[tslru_pkg::M_EVTAG_LSB +: tslru_pkg::TAG_W] = evict ? victim_tag : '0;
        m_data_next[tslru_pkg::M_OCC_LSB +: tslru_pkg::CNT_W]   =
            tslru_pkg::CNT_W'(count_next);
    end

    // Entry state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            count_reg  <= '0;
            cap_reg    <= tslru_pkg::CAP_RESET;
            policy_reg <= tslru_pkg::POLICY_LRU;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                rank_reg  <= rank_next;
            end
            if (cfg_wr_en && count_reg == '0) begin
                case (cfg_index)
                    tslru_pkg::REG_CAPACITY: cap_reg    <= cfg_wdata[tslru_pkg::CAP_W-1:0];
                    tslru_pkg::REG_POLICY:   policy_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && tag_write) begin
            tag_reg[slot_idx] <= req_tag;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/tslru_chk.sv =====
// ----------------------------------------------------------------------------
// tslru_chk : port checker for the tag store
// Watches the result stream for reset behaviour, stall stability and the
// consistency of the reported fields.
// ----------------------------------------------------------------------------
module tslru_chk #(
    parameter int MAX_ENTRIES = tslru_pkg::MAX_ENTRIES_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tslru_pkg::M_DATA_W-1:0] m_tdata
);

    // No result may be offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled result stays put.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // An eviction only happens on an insert that missed.
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[tslru_pkg::M_EVV_BIT] |-> !m_tdata[tslru_pkg::M_HIT_BIT])
        else $error("eviction reported together with a hit");

    // The victim tag reads as zero when nothing was evicted.
    a_evict_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[tslru_pkg::M_EVV_BIT]
        |-> m_tdata[tslru_pkg::M_EVTAG_LSB +: tslru_pkg::TAG_W] == '0)
        else $error("victim tag not zero without eviction");

    // Occupancy never exceeds the number of entries.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[tslru_pkg::M_OCC_LSB +: tslru_pkg::CNT_W]) <= MAX_ENTRIES))
        else $error("occupancy above the number of entries");

endmodule

bind tag_store_lru_fifo_replacement_core tslru_chk #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_tslru_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tag_store_lru_fifo_replacement_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_store_lru_fifo_replacement_core_tb : self-checking bench for the tag store
// A short table of directed requests and register writes is followed by
// randomised phases under different capacity and policy settings. Every
// result transaction is checked field by field against the behavioural
// store or a hand-written result, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tag_store_lru_fifo_replacement_core_tb;

    // Depth of the behavioural store; the block is built with its default.
    localparam int STORE_DEPTH  = tslru_pkg::MAX_ENTRIES_DEF;
    // Number of randomised phases and requests offered in each of them.
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 112;
    // Cycles the receiver refuses results during the deliberate hold-off.
    localparam int HOLD_CYCLES  = 300;
    // Watchdog limit: several times the slowest legal run of this bench.
    localparam int LIMIT_CYCLES = 800000;

    localparam logic [tslru_pkg::TAG_W-1:0] ALL_ONES = {tslru_pkg::TAG_W{1'b1}};

    // One result as the store reports it.
    typedef struct packed {
        logic                        hit;
        logic                        ev_valid;
        logic [tslru_pkg::TAG_W-1:0] ev_tag;
        logic [tslru_pkg::CNT_W-1:0] occ;
    } tag_result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // One line of the directed table: either a request (optionally with its
    // result written out by hand) or a register write.
    typedef struct packed {
        row_kind_t                        kind;
        tslru_pkg::action_t               act;
        logic [tslru_pkg::TAG_W-1:0]      tag;
        logic                             typed;
        tag_result_t                      res;
        logic [tslru_pkg::CFG_IDX_W-1:0]  cfg_idx;
        logic [tslru_pkg::CFG_DATA_W-1:0] cfg_val;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // Block ports.
    // ------------------------------------------------------------------------
    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    // s_tdata fields from bit 0: action[1:0], tag[65:2], zero pad[71:66]
    logic [tslru_pkg::S_DATA_W-1:0]   s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    // m_tdata fields from bit 0: hit[0], evicted_valid[1], evicted_tag[65:2],
    // occupancy[70:66], zero pad[71]
    logic [tslru_pkg::M_DATA_W-1:0]   m_tdata;
    logic                             cfg_wr_en;
    logic [tslru_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tslru_pkg::CFG_DATA_W-1:0] cfg_wdata;

    tag_store_lru_fifo_replacement_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Behavioural copy of the store and its registers. It is reset and
    // advanced by the monitor alone.
    // ------------------------------------------------------------------------
    logic [tslru_pkg::TAG_W-1:0] mdl_tag   [STORE_DEPTH];
    logic                        mdl_valid [STORE_DEPTH];
    int                          mdl_rank  [STORE_DEPTH];
    int                          mdl_count;
    int                          mdl_capacity;
    logic                        mdl_policy;

    // Results still owed by the block, oldest first.
    tag_result_t      pending_results[$];

    // Hand-written result for the request currently offered, if any.
    logic             cur_typed;
    tag_result_t      cur_typed_res;

    // Bookkeeping for the summary and the verdict.
    int               error_count;
    int               req_count;
    int               res_count;
    int               hit_count;
    int               evict_count;
    int               cycle_count;

    // Raised by the sender to ask the receiver for its long hold-off.
    logic             hold_req;
    logic             burst_mode;

    dir_row_t         dir_tab[$];

    // Removes entry idx and closes the gap it leaves in the age order.
    function automatic void retire_entry(int idx);
        int i;
        for (i = 0; i < STORE_DEPTH; i++) begin
            if (mdl_valid[i] && mdl_rank[i] > mdl_rank[idx]) mdl_rank[i]--;
        end
        mdl_valid[idx] = 1'b0;
        mdl_rank[idx]  = 0;
        mdl_tag[idx]   = '0;
        if (mdl_count > 0) mdl_count--;
    endfunction

    // Applies one request to the behavioural store and returns its result.
    function automatic tag_result_t apply_request(tslru_pkg::action_t act,
                                                  logic [tslru_pkg::TAG_W-1:0] tag);
        tag_result_t res;
        int          i;
        int          idx;
        int          slot;
        int          vic;
        int          cap_eff;
        int          old_rank;
        res  = '0;
        idx  = -1;
        slot = -1;
        vic  = -1;
        for (i = 0; i < STORE_DEPTH; i++) begin
            if (idx < 0 && mdl_valid[i] && mdl_tag[i] == tag) idx = i;
        end
        res.hit = (idx >= 0);
        case (act)
            tslru_pkg::ACT_ACCESS, tslru_pkg::ACT_INSERT: begin
                if (idx >= 0) begin
                    // A hit only changes the order under LRU: the entry becomes
                    // the most recent and everything newer than it ages by one.
                    if (mdl_policy == tslru_pkg::POLICY_LRU) begin
                        old_rank = mdl_rank[idx];
                        for (i = 0; i < STORE_DEPTH; i++) begin
                            if (mdl_valid[i] && mdl_rank[i] < old_rank) mdl_rank[i]++;
                        end
                        mdl_rank[idx] = 0;
                    end
                end else if (act == tslru_pkg::ACT_INSERT) begin
                    cap_eff = mdl_capacity;
                    if (cap_eff == 0) cap_eff = 1;
                    if (cap_eff > STORE_DEPTH) cap_eff = STORE_DEPTH;
                    if (mdl_count >= cap_eff) begin
                        for (i = 0; i < STORE_DEPTH; i++) begin
                            if (vic < 0 && mdl_valid[i] && mdl_rank[i] + 1 == mdl_count) vic = i;
                        end
                        if (vic >= 0) begin
                            res.ev_valid = 1'b1;
                            res.ev_tag   = mdl_tag[vic];
                            retire_entry(vic);
                        end
                    end
                    for (i = 0; i < STORE_DEPTH; i++) begin
                        if (slot < 0 && !mdl_valid[i]) slot = i;
                    end
                    if (slot >= 0) begin
                        for (i = 0; i < STORE_DEPTH; i++) begin
                            if (mdl_valid[i]) mdl_rank[i]++;
                        end
                        mdl_valid[slot] = 1'b1;
                        mdl_tag[slot]   = tag;
                        mdl_rank[slot]  = 0;
                        mdl_count++;
                    end
                end
            end
            tslru_pkg::ACT_REMOVE: begin
                if (idx >= 0) retire_entry(idx);
            end
            default: begin
                // A contains query only reports; the order is left alone.
            end
        endcase
        res.occ = mdl_count[tslru_pkg::CNT_W-1:0];
        return res;
    endfunction

    // Gap length: mostly a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_req(tslru_pkg::action_t act, logic [tslru_pkg::TAG_W-1:0] tag);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_REQ;
        row.act  = act;
        row.tag  = tag;
        dir_tab.push_back(row);
    endfunction

    function automatic void add_chk(tslru_pkg::action_t act, logic [tslru_pkg::TAG_W-1:0] tag,
                                    logic hit, logic evv,
                                    logic [tslru_pkg::TAG_W-1:0] evtag,
                                    logic [tslru_pkg::CNT_W-1:0] occ);
        dir_row_t row;
        row              = '0;
        row.kind         = ROW_REQ;
        row.act          = act;
        row.tag          = tag;
        row.typed        = 1'b1;
        row.res.hit      = hit;
        row.res.ev_valid = evv;
        row.res.ev_tag   = evtag;
        row.res.occ      = occ;
        dir_tab.push_back(row);
    endfunction

    function automatic void add_cfg(logic [tslru_pkg::CFG_IDX_W-1:0] idx,
                                    logic [tslru_pkg::CFG_DATA_W-1:0] val);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.cfg_idx = idx;
        row.cfg_val = val;
        dir_tab.push_back(row);
    endfunction

    task automatic compare_field(string name, logic [tslru_pkg::TAG_W-1:0] want,
                                 logic [tslru_pkg::TAG_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender-side tasks. Each is entered and left at a falling clock edge so
    // that every input changes only there.
    // ------------------------------------------------------------------------

    // Offers one request after an optional idle gap and waits until the block
    // takes it. The valid line is left high so that a following request can
    // go out back to back.
    task automatic send_request(tslru_pkg::action_t act, logic [tslru_pkg::TAG_W-1:0] tag,
                                logic typed, tag_result_t typed_res);
        int                             gap;
        logic [tslru_pkg::S_DATA_W-1:0] word;
        gap = 0;
        if (!burst_mode && $urandom_range(0, 99) >= 60) gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        word = '0;
        word[tslru_pkg::S_ACTION_LSB +: tslru_pkg::ACTION_W] = act;
        word[tslru_pkg::S_TAG_LSB +: tslru_pkg::TAG_W]       = tag;
        s_tvalid      <= 1'b1;
        s_tdata       <= word;
        cur_typed      = typed;
        cur_typed_res  = typed_res;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every owed result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Writes one register; the monitor mirrors the write into the
    // behavioural copy under the same rule that it only lands while the
    // store is empty.
    task automatic write_reg(logic [tslru_pkg::CFG_IDX_W-1:0] idx,
                             logic [tslru_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // If the run has not ended by the limit, something has hung.
    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. Mostly ready, with random stalls of mixed length; once the
    // sender asks for it, one long hold-off is counted out here so that the
    // output register fills and the request side backs up.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int   stall_left;
        logic hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall_left > 0 && !burst_mode) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = 0;
                if (!burst_mode && $urandom_range(0, 99) < 20) stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. At each rising edge the result side is dealt with first, so a
    // result can never be matched against the request taken at the same edge.
    // Register writes and requests then advance the behavioural copy.
    // ------------------------------------------------------------------------
    tag_result_t mon_want;
    tag_result_t mon_got;

    always @(posedge aclk) begin
        if (!aresetn) begin
            // The store comes out of reset empty, with capacity 16 and LRU.
            for (int k = 0; k < STORE_DEPTH; k++) begin
                mdl_tag[k]   = '0;
                mdl_valid[k] = 1'b0;
                mdl_rank[k]  = 0;
            end
            mdl_count    = 0;
            mdl_capacity = int'(tslru_pkg::CAP_RESET);
            mdl_policy   = tslru_pkg::POLICY_LRU;
        end else begin
            if (m_tvalid && m_tready) begin
                mon_got.hit      = m_tdata[tslru_pkg::M_HIT_BIT];
                mon_got.ev_valid = m_tdata[tslru_pkg::M_EVV_BIT];
                mon_got.ev_tag   = m_tdata[tslru_pkg::M_EVTAG_LSB +: tslru_pkg::TAG_W];
                mon_got.occ      = m_tdata[tslru_pkg::M_OCC_LSB +: tslru_pkg::CNT_W];
                if (pending_results.size() == 0) begin
                    $display("%0t ns: result transaction with none expected, %s %0h",
                             $time, "expected nothing, actual", m_tdata);
                    error_count++;
                end else begin
                    mon_want = pending_results.pop_front();
                    compare_field("hit", tslru_pkg::TAG_W'(mon_want.hit),
                                  tslru_pkg::TAG_W'(mon_got.hit));
                    compare_field("evicted_valid", tslru_pkg::TAG_W'(mon_want.ev_valid),
                                  tslru_pkg::TAG_W'(mon_got.ev_valid));
                    compare_field("evicted_tag", mon_want.ev_tag, mon_got.ev_tag);
                    compare_field("occupancy", tslru_pkg::TAG_W'(mon_want.occ),
                                  tslru_pkg::TAG_W'(mon_got.occ));
                    res_count++;
                end
            end
            if (cfg_wr_en && mdl_count == 0) begin
                if (cfg_index == tslru_pkg::REG_CAPACITY) mdl_capacity = int'(cfg_wdata);
                else if (cfg_index == tslru_pkg::REG_POLICY) mdl_policy = cfg_wdata[0];
            end
            if (s_tvalid && s_tready) begin
                // The behavioural store is always advanced; a hand-written
                // result from the directed table replaces its answer.
                mon_want = apply_request(
                    tslru_pkg::action_t'(s_tdata[tslru_pkg::S_ACTION_LSB +: tslru_pkg::ACTION_W]),
                    s_tdata[tslru_pkg::S_TAG_LSB +: tslru_pkg::TAG_W]);
                if (cur_typed) mon_want = cur_typed_res;
                if (mon_want.hit) hit_count++;
                if (mon_want.ev_valid) evict_count++;
                pending_results.push_back(mon_want);
                req_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                               i;
        int                               p;
        int                               n;
        int                               r;
        int                               pool_size;
        logic [tslru_pkg::CFG_DATA_W-1:0] cap_val;
        logic                             pol_val;
        logic [tslru_pkg::TAG_W-1:0]      tag_pool[$];
        logic [tslru_pkg::TAG_W-1:0]      flush_tags[$];
        logic [tslru_pkg::TAG_W-1:0]      tag;
        tslru_pkg::action_t               act;

        // Every block input has a known value from time zero.
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = tslru_pkg::REG_CAPACITY;
        cfg_wdata     = '0;
        cur_typed     = 1'b0;
        cur_typed_res = '0;
        hold_req      = 1'b0;
        burst_mode    = 1'b0;

        // Directed table. Results are written out only where they are plain
        // to see; the rest are left to the behavioural store.
        // Requests against the empty store straight after reset.
        add_chk(tslru_pkg::ACT_ACCESS,   '0,       1'b0, 1'b0, '0, 5'd0);
        add_chk(tslru_pkg::ACT_CONTAINS, ALL_ONES, 1'b0, 1'b0, '0, 5'd0);
        // Removing a tag that is not held changes nothing.
        add_chk(tslru_pkg::ACT_REMOVE,   64'h5,    1'b0, 1'b0, '0, 5'd0);
        add_chk(tslru_pkg::ACT_INSERT,   '0,       1'b0, 1'b0, '0, 5'd1);
        add_chk(tslru_pkg::ACT_INSERT,   ALL_ONES, 1'b0, 1'b0, '0, 5'd2);
        // Inserting a tag already held acts as an access and evicts nothing.
        add_chk(tslru_pkg::ACT_INSERT,   '0,       1'b1, 1'b0, '0, 5'd2);
        add_req(tslru_pkg::ACT_ACCESS,   ALL_ONES);
        add_req(tslru_pkg::ACT_CONTAINS, '0);
        add_chk(tslru_pkg::ACT_REMOVE,   ALL_ONES, 1'b1, 1'b0, '0, 5'd1);
        add_chk(tslru_pkg::ACT_REMOVE,   ALL_ONES, 1'b0, 1'b0, '0, 5'd1);
        // This write lands while one tag is still held, so it must be ignored
        // and the next insert must not evict.
        add_cfg(tslru_pkg::REG_CAPACITY, 5'd1);
        add_req(tslru_pkg::ACT_INSERT,   64'h1111);
        add_req(tslru_pkg::ACT_REMOVE,   '0);
        add_req(tslru_pkg::ACT_REMOVE,   64'h1111);
        // Smallest capacity under FIFO: every new tag pushes the old one out.
        add_cfg(tslru_pkg::REG_CAPACITY, 5'd1);
        add_cfg(tslru_pkg::REG_POLICY,   tslru_pkg::CFG_DATA_W'(tslru_pkg::POLICY_FIFO));
        add_req(tslru_pkg::ACT_INSERT,   64'hAAAA_AAAA_AAAA_AAAA);
        add_chk(tslru_pkg::ACT_INSERT,   64'h5555_5555_5555_5555, 1'b0, 1'b1,
                64'hAAAA_AAAA_AAAA_AAAA, 5'd1);
        // An access under FIFO reports the hit without reordering.
        add_req(tslru_pkg::ACT_ACCESS,   64'h5555_5555_5555_5555);
        add_req(tslru_pkg::ACT_REMOVE,   64'h5555_5555_5555_5555);
        // A capacity of zero behaves as a capacity of one.
        add_cfg(tslru_pkg::REG_CAPACITY, 5'd0);
        add_req(tslru_pkg::ACT_INSERT,   64'h1);
        add_chk(tslru_pkg::ACT_INSERT,   64'h2,    1'b0, 1'b1, 64'h1, 5'd1);
        add_req(tslru_pkg::ACT_CONTAINS, 64'h2);
        add_req(tslru_pkg::ACT_REMOVE,   64'h2);
        // The largest register value saturates to the full store depth.
        add_cfg(tslru_pkg::REG_CAPACITY, 5'd31);
        add_cfg(tslru_pkg::REG_POLICY,   tslru_pkg::CFG_DATA_W'(tslru_pkg::POLICY_LRU));
        add_req(tslru_pkg::ACT_INSERT,   64'h3);
        add_req(tslru_pkg::ACT_INSERT,   64'h4);
        add_req(tslru_pkg::ACT_REMOVE,   64'h3);
        add_req(tslru_pkg::ACT_REMOVE,   64'h4);

        // Synchronous reset, held from time zero and never raised again.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < dir_tab.size(); i++) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                // Registers only change with no transaction in flight.
                drain_results();
                write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
            end else begin
                send_request(dir_tab[i].act, dir_tab[i].tag, dir_tab[i].typed,
                             dir_tab[i].res);
            end
        end

        // Randomised phases. The first six cover the extremes of both
        // registers; the remainder draw their settings at random.
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            burst_mode = 1'b0;
            if (mdl_count != 0) begin
                // A write into a non-empty store is expected to be ignored.
                write_reg(tslru_pkg::REG_CAPACITY,
                          tslru_pkg::CFG_DATA_W'($urandom_range(0, 31)));
                flush_tags.delete();
                for (i = 0; i < STORE_DEPTH; i++) begin
                    if (mdl_valid[i]) flush_tags.push_back(mdl_tag[i]);
                end
                foreach (flush_tags[n]) begin
                    send_request(tslru_pkg::ACT_REMOVE, flush_tags[n], 1'b0, '0);
                end
                drain_results();
            end
            case (p)
                0:       cap_val = 5'd16;
                1:       cap_val = 5'd1;
                2:       cap_val = 5'd4;
                3:       cap_val = 5'd0;
                4:       cap_val = 5'd31;
                5:       cap_val = 5'd8;
                default: cap_val = tslru_pkg::CFG_DATA_W'($urandom_range(0, 31));
            endcase
            pol_val = (p < 6) ? p[0] : 1'($urandom_range(0, 1));
            write_reg(tslru_pkg::REG_CAPACITY, cap_val);
            write_reg(tslru_pkg::REG_POLICY, tslru_pkg::CFG_DATA_W'(pol_val));

            // A pool a little larger than the capacity keeps hits, misses
            // and evictions all common.
            pool_size = (cap_val == 0) ? 1 : (cap_val > STORE_DEPTH) ? STORE_DEPTH : cap_val;
            pool_size = pool_size + $urandom_range(1, 4);
            tag_pool.delete();
            for (i = 0; i < pool_size; i++) begin
                r = $urandom_range(0, 19);
                if (r == 0) tag_pool.push_back('0);
                else if (r == 1) tag_pool.push_back(ALL_ONES);
                else tag_pool.push_back({$urandom, $urandom});
            end

            // Every fourth phase runs with neither side idling.
            burst_mode = (p % 4 == 2);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while requests keep coming.
                if (p == 1 && n == 40) hold_req = 1'b1;
                // Sender pause until every owed result has arrived.
                if (p == 3 && n == 60) drain_results();
                r = $urandom_range(0, 99);
                if (r < 40) act = tslru_pkg::ACT_INSERT;
                else if (r < 65) act = tslru_pkg::ACT_ACCESS;
                else if (r < 80) act = tslru_pkg::ACT_CONTAINS;
                else act = tslru_pkg::ACT_REMOVE;
                if ($urandom_range(0, 99) < 88)
                    tag = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
                else
                    tag = {$urandom, $urandom};
                send_request(act, tag, 1'b0, '0);
            end
        end

        // Let the last results out, then watch a few more cycles for strays.
        drain_results();
        burst_mode = 1'b0;
        repeat (8) @(negedge aclk);

        $display("Summary: %0d requests over %0d register phases, %0d results checked.",
                 req_count, NUM_PHASES, res_count);
        $display("Summary: %0d hits and %0d evictions seen under both policies.",
                 hit_count, evict_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
